>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL of the TLB refill block.
// Simulation builds get the property checks; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// When a holds at a clock edge, b holds at the same edge
`define ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed: same-cycle implication");

// When a holds at a clock edge, b holds at the next edge
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst, a, b)

`define ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

>>> hdl/tlbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tlbr_pkg: shared types and constants of the TLB refill block
// Field widths, register codes, status codes and controller commands.
// ---------------------------------------------------------------------------
package tlbr_pkg;

   // Geometry fixed by the request and response field widths
   localparam int TLB_ENTRIES = 4;
   localparam int MAX_PAGES   = 1024;
   localparam int PHYS_PAGES  = 32;
   localparam int AGE_BITS    = 16;

   localparam int VPAGE_W = $clog2(MAX_PAGES);
   localparam int PPAGE_W = $clog2(PHYS_PAGES);
   localparam int SLOT_W  = $clog2(TLB_ENTRIES);
   localparam int FLAG_W  = 3;
   localparam int PTS_W   = 11;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = PTS_W;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PTS    = 1'b1;

   localparam logic [PTS_W-1:0] PTS_RESET = PTS_W'(1024);
   localparam logic [PTS_W-1:0] PTS_MAX   = PTS_W'(MAX_PAGES);

   // Replacement policy
   localparam logic POLICY_AGE = 1'b0;
   localparam logic POLICY_RR  = 1'b1;

   // Response status codes
   localparam logic [1:0] ST_INSTALLED    = 2'd0;
   localparam logic [1:0] ST_RANGE        = 2'd1;
   localparam logic [1:0] ST_NOT_RESIDENT = 2'd2;

   typedef struct packed {
      logic [VPAGE_W-1:0] virt_page;
      logic [PPAGE_W-1:0] phys_page;
      logic               read_only;
      logic               used_flag;
      logic               dirty_flag;
      logic               page_resident;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [SLOT_W-1:0]  slot;
      logic               evicted;
      logic [VPAGE_W-1:0] evicted_page;
      logic               needs_page_in;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;    // capture the request
      logic commit;  // decide, update the slots, register the response
   } cmd_type;

endpackage

`default_nettype wire

>>> hdl/tlbr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// tlbr_ctrl: request sequencer
// Two-state controller: accepts a request, then runs its execute state.
// ---------------------------------------------------------------------------
module tlbr_ctrl
   import tlbr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   output cmd_type      cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff;
   logic state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands and handshake
   assign busy       = (state_ff == S_EXEC);
   assign cmd.load   = start && !busy;
   assign cmd.commit = (state_ff == S_EXEC);

   `ASSERT_NEXT(a_accept_sets_busy, clock, reset, start && !busy, busy)
   `ASSERT_NEXT(a_exec_single_cycle, clock, reset, state_ff == S_EXEC, state_ff == S_IDLE)
   `ASSERT_IMPLY(a_commit_after_load, clock, reset, cmd.commit, $past(cmd.load))

endmodule

`default_nettype wire

>>> hdl/tlbr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// tlbr_datapath: slot storage, victim selection and response register
// Holds the TLB slots, ages, round-robin pointer and config registers.
// ---------------------------------------------------------------------------
module tlbr_datapath
   import tlbr_pkg::*;
#(
   parameter int AGE_W = AGE_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   input  wire req_type               req_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                       rsp_valid,
   output rsp_type                    rsp_data
);

   localparam logic [AGE_W-1:0]  AGE_MAX  = {AGE_W{1'b1}};
   localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(TLB_ENTRIES - 1);

   // Configuration
   logic             policy_ff;
   logic [PTS_W-1:0] pts_ff;

   // Captured request
   req_type req_ff;

   // Slot state
   logic [TLB_ENTRIES-1:0] valid_ff;
   logic [AGE_W-1:0]       age_ff   [TLB_ENTRIES];
   logic [VPAGE_W-1:0]     vpage_ff [TLB_ENTRIES];
   logic [PPAGE_W-1:0]     ppage_ff [TLB_ENTRIES];
   logic [FLAG_W-1:0]      flags_ff [TLB_ENTRIES];
   logic [SLOT_W-1:0]      rr_ptr_ff;

   // Response register
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_in;

   // Decision signals
   logic [PTS_W-1:0]  limit;
   logic              out_of_range;
   logic              any_free;
   logic [SLOT_W-1:0] free_idx;
   logic [SLOT_W-1:0] oldest_idx;
   logic [AGE_W-1:0]  oldest_age;
   logic [SLOT_W-1:0] target;
   logic [1:0]        status;
   logic              install;
   logic              evict;

   // Page limit, saturated at the table size
   assign limit        = (pts_ff > PTS_MAX) ? PTS_MAX : pts_ff;
   assign out_of_range = ({{(PTS_W - VPAGE_W){1'b0}}, req_ff.virt_page} >= limit);

   // Lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) free_idx = SLOT_W'(i);
      end
   end
   assign any_free = ~&valid_ff;

   // Oldest slot, lowest index on ties
   always_comb begin
      oldest_idx = '0;
      oldest_age = age_ff[0];
      for (int i = 1; i < TLB_ENTRIES; i++) begin
         if (age_ff[i] > oldest_age) begin
            oldest_age = age_ff[i];
            oldest_idx = SLOT_W'(i);
         end
      end
   end

   // Status and target slot
   always_comb begin
      if (out_of_range) begin
         status = ST_RANGE;
      end else if ((policy_ff == POLICY_RR) && !req_ff.page_resident) begin
         status = ST_NOT_RESIDENT;
      end else begin
         status = ST_INSTALLED;
      end
   end

   assign install = (status == ST_INSTALLED);
   assign evict   = install && !any_free;

   always_comb begin
      if (any_free) begin
         target = free_idx;
      end else if (policy_ff == POLICY_AGE) begin
         target = oldest_idx;
      end else begin
         target = rr_ptr_ff;
      end
   end

   // Response fields; zero when rejected or nothing evicted
   always_comb begin
      rsp_in.status        = status;
      rsp_in.slot          = install ? target : '0;
      rsp_in.evicted       = evict;
      rsp_in.evicted_page  = evict ? vpage_ff[target] : '0;
      rsp_in.needs_page_in = install && (policy_ff == POLICY_AGE) && !req_ff.page_resident;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_AGE;
         pts_ff    <= PTS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_POLICY: policy_ff <= csr_wdata[0];
            CSR_PTS:    pts_ff    <= csr_wdata[PTS_W-1:0];
            default:    ;
         endcase
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
   end

   // Entry contents, no reset
   always_ff @(posedge clock) begin
      if (cmd.commit && install) begin
         vpage_ff[target] <= req_ff.virt_page;
         ppage_ff[target] <= req_ff.phys_page;
         flags_ff[target] <= {req_ff.dirty_flag, req_ff.used_flag, req_ff.read_only};
      end
   end

   // Valid bits, ages and round-robin pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rr_ptr_ff <= '0;
         for (int i = 0; i < TLB_ENTRIES; i++) begin
            age_ff[i] <= '0;
         end
      end else if (cmd.commit && install) begin
         valid_ff[target] <= 1'b1;
         if (policy_ff == POLICY_AGE) begin
            for (int i = 0; i < TLB_ENTRIES; i++) begin
               if (SLOT_W'(i) == target) begin
                  age_ff[i] <= '0;
               end else if ((valid_ff[i] || evict) && (age_ff[i] != AGE_MAX)) begin
                  age_ff[i] <= age_ff[i] + 1'b1;
               end
            end
         end else if (evict) begin
            rr_ptr_ff <= (target == SLOT_TOP) ? '0 : target + 1'b1;
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_IMPLY(a_rsp_from_commit, clock, reset, rsp_valid_ff, $past(cmd.commit))
   `ASSERT_IMPLY(a_evict_installs, clock, reset, rsp_valid_ff && rsp_ff.evicted, rsp_ff.status == ST_INSTALLED)
   `ASSERT_IMPLY(a_pagein_age_only, clock, reset, rsp_valid_ff && rsp_ff.needs_page_in, policy_ff == POLICY_AGE)
   `ASSERT_IMPLY(a_valid_never_drops, clock, reset, 1'b1, (valid_ff & $past(valid_ff)) == $past(valid_ff))

endmodule

`default_nettype wire

>>> hdl/tlb_refill_replacement_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tlb_refill_replacement_core: TLB refill and replacement unit
// Installs a page-table entry into a small TLB after a miss.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_data and raise start; the request is taken at
//   a rising edge with start high and busy low. busy is high for one cycle
//   after each accepted request.
//   Response channel: rsp_valid is high for exactly one cycle with rsp_data,
//   registered from the execute state. The receiver cannot stall it; it
//   must take every response in that cycle. A new request can be accepted in
//   the same cycle as a response is shown.
//   Requests: a new request is not taken while busy, that is, during the
//   execute state, in which the free-slot search, the oldest-age compare and
//   the slot update all complete.
//   Configuration: csr_we with csr_index 0 (policy, 0 age, 1 round-robin) or
//   1 (page-table size); write only while no request is in flight.
//   Reset (synchronous, active high): all slots invalid, ages and the
//   round-robin pointer zero, age policy, page-table size 1024.
// ---------------------------------------------------------------------------
module tlb_refill_replacement_core
   import tlbr_pkg::*;
#(
   parameter int AGE_W = AGE_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type cmd;

   // Sequencer
   tlbr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // Slot storage and decision logic
   tlbr_datapath #(
      .AGE_W (AGE_W)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for tlb_refill_replacement_core
// Drives refill requests and register writes from a pending queue, predicts
// each response with a local model of the slot table (validity, pages,
// ages, round-robin pointer) and checks every response field by field.
// ---------------------------------------------------------------------------
module testbench;
   import tlbr_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int PHASES      = 10;
   localparam int PHASE_REQS  = 125;

   typedef enum logic [1:0] {OP_REQ, OP_CSR, OP_DRAIN, OP_IDLE} op_kind_type;

   typedef struct {
      op_kind_type            kind;
      req_type                rq;
      logic [CSR_IDX_W-1:0]   idx;
      logic [CSR_DATA_W-1:0]  val;
      int                     pct;
   } pend_op_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pend_op_type pend_q[$];
   rsp_type     refill_q[$];

   // Local copy of the slot table and registers
   logic                 tlb_valid [TLB_ENTRIES];
   logic [VPAGE_W-1:0]   tlb_vpage [TLB_ENTRIES];
   logic [AGE_BITS-1:0]  tlb_age   [TLB_ENTRIES];
   logic [SLOT_W-1:0]    rr_ptr;
   logic                 cfg_policy;
   logic [PTS_W-1:0]     cfg_pts;

   int  send_idle_pct = 0;
   int  err_count     = 0;
   int  stall_cycles  = 0;
   bit  took_req      = 0;
   bit  bench_idle    = 0;

   tlb_refill_replacement_core uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      err_count++;
      $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
   endtask

   task automatic clear_slot_table();
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         tlb_valid[i] = 1'b0;
         tlb_vpage[i] = '0;
         tlb_age[i]   = '0;
      end
      rr_ptr     = '0;
      cfg_policy = POLICY_AGE;
      cfg_pts    = PTS_RESET;
   endtask

   // Refill decision: range check, residency check, then victim selection
   task automatic compute_refill(input req_type rq, output rsp_type rs);
      logic [PTS_W-1:0] lim;
      int               tgt;
      bit               found;
      rs    = '0;
      tgt   = 0;
      found = 0;
      lim   = (cfg_pts > PTS_MAX) ? PTS_MAX : cfg_pts;
      if ({1'b0, rq.virt_page} >= lim) begin
         rs.status = ST_RANGE;
      end else if (cfg_policy == POLICY_RR && !rq.page_resident) begin
         rs.status = ST_NOT_RESIDENT;
      end else begin
         rs.status = ST_INSTALLED;
         // lowest invalid slot
         for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (!tlb_valid[i]) begin
               tgt   = i;
               found = 1;
            end
         end
         if (cfg_policy == POLICY_AGE) begin
            if (found) begin
               for (int i = 0; i < TLB_ENTRIES; i++)
                  if (tlb_valid[i] && tlb_age[i] != '1) tlb_age[i]++;
            end else begin
               // oldest slot, lowest index on ties
               tgt = 0;
               for (int i = 1; i < TLB_ENTRIES; i++)
                  if (tlb_age[i] > tlb_age[tgt]) tgt = i;
               for (int i = 0; i < TLB_ENTRIES; i++)
                  if (tlb_age[i] != '1) tlb_age[i]++;
               rs.evicted      = 1'b1;
               rs.evicted_page = tlb_vpage[tgt];
            end
            tlb_age[tgt]     = '0;
            rs.needs_page_in = !rq.page_resident;
         end else if (!found) begin
            tgt             = rr_ptr;
            rs.evicted      = 1'b1;
            rs.evicted_page = tlb_vpage[tgt];
            rr_ptr          = rr_ptr + 1'b1;
         end
         tlb_valid[tgt] = 1'b1;
         tlb_vpage[tgt] = rq.virt_page;
         rs.slot        = SLOT_W'(tgt);
      end
   endtask

   task automatic push_req(input int vp, input int pp, input bit ro, input bit uf,
                           input bit df, input bit res);
      pend_op_type op;
      op                  = '{default: 0, kind: OP_REQ};
      op.rq.virt_page     = VPAGE_W'(vp);
      op.rq.phys_page     = PPAGE_W'(pp);
      op.rq.read_only     = ro;
      op.rq.used_flag     = uf;
      op.rq.dirty_flag    = df;
      op.rq.page_resident = res;
      pend_q.push_back(op);
   endtask

   task automatic push_csr(input logic [CSR_IDX_W-1:0] idx, input int val);
      pend_op_type op;
      op     = '{default: 0, kind: OP_CSR};
      op.idx = idx;
      op.val = CSR_DATA_W'(val);
      pend_q.push_back(op);
   endtask

   task automatic push_marker(input op_kind_type kind, input int pct);
      pend_op_type op;
      op     = '{default: 0, kind: kind};
      op.pct = pct;
      pend_q.push_back(op);
   endtask

   // Driver: one decision per falling edge, each input assigned once
   always @(negedge clock) begin
      logic                  nxt_start;
      req_type               nxt_data;
      logic                  nxt_we;
      logic [CSR_IDX_W-1:0]  nxt_idx;
      logic [CSR_DATA_W-1:0] nxt_val;
      if (!reset) begin
         nxt_start = start;
         nxt_data  = req_data;
         nxt_we    = 1'b0;
         nxt_idx   = csr_index;
         nxt_val   = csr_wdata;
         if (!start || took_req) begin
            nxt_start = 1'b0;
            while (pend_q.size() > 0 && pend_q[0].kind == OP_IDLE) begin
               send_idle_pct = pend_q[0].pct;
               void'(pend_q.pop_front());
            end
            if (pend_q.size() > 0) begin
               case (pend_q[0].kind)
                  OP_REQ: begin
                     if ($urandom_range(99) >= send_idle_pct) begin
                        nxt_start = 1'b1;
                        nxt_data  = pend_q[0].rq;
                        void'(pend_q.pop_front());
                     end
                  end
                  OP_CSR: begin
                     // registers change only with no request in flight
                     if (refill_q.size() == 0) begin
                        nxt_we  = 1'b1;
                        nxt_idx = pend_q[0].idx;
                        nxt_val = pend_q[0].val;
                        void'(pend_q.pop_front());
                     end
                  end
                  OP_DRAIN: begin
                     if (refill_q.size() == 0) void'(pend_q.pop_front());
                  end
                  default: void'(pend_q.pop_front());
               endcase
            end
         end
         start      <= nxt_start;
         req_data   <= nxt_data;
         csr_we     <= nxt_we;
         csr_index  <= nxt_idx;
         csr_wdata  <= nxt_val;
         bench_idle <= (pend_q.size() == 0) && !nxt_start && (refill_q.size() == 0);
      end
   end

   // Monitor: check responses, track registers, predict accepted requests
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_slot_table();
         refill_q.delete();
         took_req     <= 1'b0;
         stall_cycles <= 0;
      end else begin
         if (rsp_valid) begin
            if (refill_q.size() == 0) begin
               report_mismatch("response with no request pending", 1, 0);
            end else begin
               want = refill_q.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.slot !== want.slot)
                  report_mismatch("slot", rsp_data.slot, want.slot);
               if (rsp_data.evicted !== want.evicted)
                  report_mismatch("evicted", rsp_data.evicted, want.evicted);
               if (rsp_data.evicted_page !== want.evicted_page)
                  report_mismatch("evicted_page", rsp_data.evicted_page, want.evicted_page);
               if (rsp_data.needs_page_in !== want.needs_page_in)
                  report_mismatch("needs_page_in", rsp_data.needs_page_in, want.needs_page_in);
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_POLICY: cfg_policy = csr_wdata[0];
               CSR_PTS:    cfg_pts    = csr_wdata;
               default:    ;
            endcase
         end
         if (start && !busy) begin
            compute_refill(req_data, want);
            refill_q.push_back(want);
         end
         took_req <= start && !busy;
         if (rsp_valid || csr_we || (start && !busy))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
      end
   end

   // Stimulus and end of run
   initial begin
      int pts;
      int lim;
      int vp;
      clock     = 1'b0;
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_POLICY;
      csr_wdata = '0;

      // Directed: round-robin on an empty table first, since slots never free up
      push_csr(CSR_POLICY, POLICY_RR);
      push_req(5, 1, 0, 0, 0, 1);
      push_req(6, 2, 1, 0, 1, 0);             // not resident, rejected
      push_req(1023, 31, 1, 1, 1, 1);
      push_csr(CSR_POLICY, POLICY_AGE);
      push_req(0, 0, 0, 0, 0, 0);             // free slot, page-in needed
      push_req(512, 16, 0, 1, 0, 1);
      push_req(100, 3, 1, 0, 0, 1);           // table full, oldest evicted
      push_req(101, 4, 0, 0, 1, 0);
      push_csr(CSR_PTS, 0);
      push_req(0, 7, 0, 0, 0, 1);             // everything out of range
      push_csr(CSR_PTS, 2047);                // limit saturates at the maximum
      push_req(1023, 8, 1, 1, 1, 1);
      push_csr(CSR_PTS, 1023);
      push_req(1023, 9, 0, 0, 0, 1);
      push_req(1022, 10, 0, 1, 1, 0);
      push_csr(CSR_POLICY, POLICY_RR);
      push_req(1023, 11, 0, 0, 0, 0);         // range check wins over residency
      push_req(7, 12, 0, 0, 0, 0);
      push_req(8, 13, 1, 0, 1, 1);            // pointer still at slot zero
      push_req(9, 14, 0, 1, 0, 1);
      push_req(10, 15, 1, 1, 0, 1);
      push_csr(CSR_PTS, 1024);
      push_marker(OP_DRAIN, 0);

      // Random phases, cycling the sender idle rate
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph % 3)
            0: push_marker(OP_IDLE, 0);
            1: push_marker(OP_IDLE, 59);
            default: push_marker(OP_IDLE, 35);
         endcase
         if (ph == 0)
            push_csr(CSR_POLICY, POLICY_AGE);
         else if (ph == 1)
            push_csr(CSR_POLICY, POLICY_RR);
         else
            push_csr(CSR_POLICY, $urandom_range(1));
         case ($urandom_range(5))
            0, 1: pts = 1024;
            2:    pts = 2047;
            3:    pts = $urandom_range(1, 16);
            4:    pts = 1023;
            default: pts = $urandom_range(2047);
         endcase
         push_csr(CSR_PTS, pts);
         lim = (pts > MAX_PAGES) ? MAX_PAGES : pts;
         for (int k = 0; k < PHASE_REQS; k++) begin
            // hold off until the pipeline is empty
            if (k == PHASE_REQS / 2 && ph % 2 == 1) push_marker(OP_DRAIN, 0);
            if ($urandom_range(99) < 85 && lim > 0)
               vp = $urandom_range(lim - 1);
            else
               vp = $urandom_range(1023);
            push_req(vp, $urandom_range(31), $urandom_range(1), $urandom_range(1),
                     $urandom_range(1), $urandom_range(99) < 70);
         end
      end
      push_marker(OP_DRAIN, 0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (!bench_idle && stall_cycles < STALL_LIMIT) @(negedge clock);
      if (stall_cycles >= STALL_LIMIT) begin
         $display("tlb_refill_replacement_core verification failed");
      end else begin
         repeat (8) @(posedge clock);
         if (err_count == 0) begin
            $display("tlb_refill_replacement_core verification clean");
         end else begin
            $display("tlb_refill_replacement_core verification failed");
         end
      end
      $finish;
   end

endmodule
